// File: sv/imu_caf_pkg.sv
// ----------------------------------------------------------------------------
// imu_caf_pkg
// Types, constants and the arctangent table of the attitude filter.
// ----------------------------------------------------------------------------
package imu_caf_pkg;

  localparam int FieldW  = 16;
  localparam int AngW    = 32;
  localparam int RangeW  = 2;
  localparam int StepW   = 24;
  localparam int CfgIdxW = 4;
  localparam int CfgDatW = 24;
  localparam int MagW    = 18;

  localparam int MulAW   = 33;
  localparam int MulBW   = 26;
  localparam int MulPW   = MulAW + MulBW;
  localparam int AccW    = 60;

  localparam int CordW   = 36;
  localparam int ZW      = 26;
  localparam int TabIdxW = 5;
  localparam int CordPreShift = 16;

  localparam int MagLow      = 8192;
  localparam int MagHigh     = 32768;
  localparam int RangeReset  = 0;
  localparam int StepReset   = 83886;
  localparam int RoundInt    = 1 << 22;
  localparam int IntShift    = 23;
  localparam int BlendKeep   = 64225;
  localparam int BlendGain   = 1311;
  localparam int BlendHalf   = 1 << 15;
  localparam int BlendShift  = 16;

  localparam logic signed [ZW-1:0] Deg90  = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] Deg180 = ZW'(180 * 65536);

  typedef enum logic [CfgIdxW-1:0] {
    REG_GYRO_RANGE = 4'd0,
    REG_TIME_STEP  = 4'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    AX_PITCH = 2'd0,
    AX_ROLL  = 2'd1,
    AX_YAW   = 2'd2
  } axis_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INT_MUL,
    ST_INT_ADD,
    ST_ATAN_START,
    ST_ATAN_WAIT,
    ST_BLEND_ANG,
    ST_BLEND_TILT,
    ST_BLEND_ADD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [FieldW-1:0] accel_x;
    logic signed [FieldW-1:0] accel_y;
    logic signed [FieldW-1:0] accel_z;
    logic signed [FieldW-1:0] gyro_x;
    logic signed [FieldW-1:0] gyro_y;
    logic signed [FieldW-1:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic signed [AngW-1:0] pitch_deg;
    logic signed [AngW-1:0] roll_deg;
    logic signed [AngW-1:0] yaw_deg;
    logic                   accel_blended;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] value;
  } cfg_item_t;

  // atan(2^-i) in degrees, q16
  function automatic logic signed [ZW-1:0] atan_tab_q16(input logic [TabIdxW-1:0] idx);
    case (idx)
      5'd0:    atan_tab_q16 = ZW'(2949120);
      5'd1:    atan_tab_q16 = ZW'(1740967);
      5'd2:    atan_tab_q16 = ZW'(919879);
      5'd3:    atan_tab_q16 = ZW'(466945);
      5'd4:    atan_tab_q16 = ZW'(234379);
      5'd5:    atan_tab_q16 = ZW'(117304);
      5'd6:    atan_tab_q16 = ZW'(58666);
      5'd7:    atan_tab_q16 = ZW'(29335);
      5'd8:    atan_tab_q16 = ZW'(14668);
      5'd9:    atan_tab_q16 = ZW'(7334);
      5'd10:   atan_tab_q16 = ZW'(3667);
      5'd11:   atan_tab_q16 = ZW'(1833);
      5'd12:   atan_tab_q16 = ZW'(917);
      5'd13:   atan_tab_q16 = ZW'(458);
      5'd14:   atan_tab_q16 = ZW'(229);
      5'd15:   atan_tab_q16 = ZW'(115);
      5'd16:   atan_tab_q16 = ZW'(57);
      5'd17:   atan_tab_q16 = ZW'(29);
      5'd18:   atan_tab_q16 = ZW'(14);
      5'd19:   atan_tab_q16 = ZW'(7);
      5'd20:   atan_tab_q16 = ZW'(4);
      5'd21:   atan_tab_q16 = ZW'(2);
      5'd22:   atan_tab_q16 = ZW'(1);
      default: atan_tab_q16 = '0;
    endcase
  endfunction

  // clamp to the signed 32-bit angle range
  function automatic logic signed [AngW-1:0] sat_ang(input logic signed [AccW-1:0] v);
    if (v[AccW-1:AngW-1] == '0 || v[AccW-1:AngW-1] == '1) begin
      sat_ang = v[AngW-1:0];
    end else if (v[AccW-1]) begin
      sat_ang = {1'b1, {(AngW-1){1'b0}}};
    end else begin
      sat_ang = {1'b0, {(AngW-1){1'b1}}};
    end
  endfunction

endpackage

// File: sv/imu_caf_if.sv
// ----------------------------------------------------------------------------
// imu_caf_if
// Valid/ready channels of the attitude filter: sample, result and config.
// ----------------------------------------------------------------------------
interface imu_caf_in_if;
  logic                  valid;
  logic                  ready;
  imu_caf_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface imu_caf_out_if;
  logic                   valid;
  logic                   ready;
  imu_caf_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface imu_caf_cfg_if;
  logic                   valid;
  logic                   ready;
  imu_caf_pkg::cfg_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: sv/imu_caf_mul.sv
// ----------------------------------------------------------------------------
// imu_caf_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module imu_caf_mul (
  input  logic                                   clk_i,
  input  logic signed [imu_caf_pkg::MulAW-1:0]   a_i,
  input  logic signed [imu_caf_pkg::MulBW-1:0]   b_i,
  output logic signed [imu_caf_pkg::MulPW-1:0]   p_o
);
  import imu_caf_pkg::*;

  logic signed [MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule

// File: sv/imu_caf_cordic.sv
// ----------------------------------------------------------------------------
// imu_caf_cordic
// Iterative vectoring CORDIC: atan2(y, x) in degrees q16, one step a cycle.
// ----------------------------------------------------------------------------
module imu_caf_cordic #(
  parameter int unsigned Steps = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [imu_caf_pkg::FieldW-1:0] y_i,
  input  logic signed [imu_caf_pkg::FieldW-1:0] x_i,
  output logic                                  done_o,
  output logic signed [imu_caf_pkg::ZW-1:0]     z_o
);
  import imu_caf_pkg::*;

  localparam logic [TabIdxW-1:0] LastStep = TabIdxW'(Steps - 1);

  logic                     busy_q;
  logic                     done_q;
  logic [TabIdxW-1:0]       cnt_q;
  logic signed [CordW-1:0]  x_q;
  logic signed [CordW-1:0]  y_q;
  logic signed [ZW-1:0]     z_q;

  logic signed [FieldW:0]   xe;
  logic signed [FieldW:0]   ye;
  logic signed [FieldW:0]   xr;
  logic signed [FieldW:0]   yr;
  logic signed [ZW-1:0]     zr;
  logic signed [ZW-1:0]     zs;
  logic                     special;
  logic signed [CordW-1:0]  xs;
  logic signed [CordW-1:0]  ys;
  logic                     y_pos;

  // axis cases and quarter-turn pre-rotation
  always_comb begin
    xe      = (FieldW+1)'(x_i);
    ye      = (FieldW+1)'(y_i);
    special = (y_i == '0) || (x_i == '0);
    if (y_i == '0) begin
      zs = x_i[FieldW-1] ? Deg180 : '0;
    end else begin
      zs = y_i[FieldW-1] ? -Deg90 : Deg90;
    end
    xr = xe;
    yr = ye;
    zr = '0;
    if (x_i[FieldW-1]) begin
      if (!y_i[FieldW-1]) begin
        xr = ye;
        yr = -xe;
        zr = Deg90;
      end else begin
        xr = -ye;
        yr = xe;
        zr = -Deg90;
      end
    end
  end

  assign xs    = x_q >>> cnt_q;
  assign ys    = y_q >>> cnt_q;
  assign y_pos = !y_q[CordW-1] && (y_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= !special;
        done_q <= special;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= CordW'(xr) <<< CordPreShift;
      y_q <= CordW'(yr) <<< CordPreShift;
      z_q <= special ? zs : zr;
    end else if (busy_q) begin
      if (y_pos) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_tab_q16(cnt_q);
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_tab_q16(cnt_q);
      end
    end
  end

  assign done_o = done_q;
  assign z_o    = z_q;

endmodule

// File: sv/imu_complementary_attitude_filter.sv
// ----------------------------------------------------------------------------
// imu_complementary_attitude_filter
// Complementary attitude filter: gyro integration with accelerometer tilt
// correction of pitch and roll, angles in signed q15.16 degrees.
// ----------------------------------------------------------------------------
// One sample transaction is taken at a time. Gyro integration of the three
// axes goes through one shared multiplier; when the accelerometer magnitude
// is out of band the transaction ends there. When the tilt correction
// applies, each of pitch and roll then runs one atan2 on the iterative
// CORDIC and blends angle and tilt through the shared multiplier.
// The result sits in an output register, so the next sample is taken while it
// waits to be read. Configuration writes are accepted every cycle.
module imu_complementary_attitude_filter #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  imu_caf_in_if.sink   in_i,
  imu_caf_out_if.source out_o,
  imu_caf_cfg_if.sink  cfg_i
);
  import imu_caf_pkg::*;

  localparam int NumAxes = 3;

  state_e                  state_q, state_d;
  axis_e                   axis_q, axis_d;
  logic signed [AngW-1:0]  angle_q [NumAxes];
  logic signed [AngW-1:0]  angle_d [NumAxes];
  logic signed [ZW-1:0]    tilt_q, tilt_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  out_item_t               out_data_q, out_data_d;
  logic                    out_valid_q, out_valid_d;
  in_item_t                item_q;
  logic                    blend_q;
  logic [RangeW-1:0]       range_q;
  logic [StepW-1:0]        time_step_q;

  logic [FieldW:0]         abs_x, abs_y, abs_z;
  logic [MagW-1:0]         mag;
  logic                    mag_ok;

  logic signed [FieldW-1:0] gyro_sel;
  logic signed [FieldW+8:0] g250;
  logic signed [MulAW-1:0]  rate_a;
  logic signed [MulBW-1:0]  step_b;
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [MulPW-1:0]  mul_p;

  logic signed [MulPW-1:0]  int_round;
  logic signed [MulPW-1:0]  int_inc;
  logic signed [AngW+1:0]   int_sum;
  logic signed [AngW-1:0]   int_angle;
  logic signed [AccW-1:0]   blend_sum;
  logic signed [AccW-1:0]   blend_shift;
  logic signed [AngW-1:0]   blend_angle;

  logic                     cordic_start;
  logic                     cordic_done;
  logic signed [FieldW-1:0] cordic_y;
  logic signed [ZW-1:0]     cordic_z;

  // absolute-sum magnitude of the incoming accelerometer sample
  assign abs_x  = in_i.data.accel_x[FieldW-1] ? (FieldW+1)'(-(FieldW+1)'(in_i.data.accel_x))
                                              : (FieldW+1)'(in_i.data.accel_x);
  assign abs_y  = in_i.data.accel_y[FieldW-1] ? (FieldW+1)'(-(FieldW+1)'(in_i.data.accel_y))
                                              : (FieldW+1)'(in_i.data.accel_y);
  assign abs_z  = in_i.data.accel_z[FieldW-1] ? (FieldW+1)'(-(FieldW+1)'(in_i.data.accel_z))
                                              : (FieldW+1)'(in_i.data.accel_z);
  assign mag    = MagW'(abs_x) + MagW'(abs_y) + MagW'(abs_z);
  assign mag_ok = (mag > MagW'(MagLow)) && (mag < MagW'(MagHigh));

  // rate times full scale: 250 * 2^range
  always_comb begin
    case (axis_q)
      AX_PITCH: gyro_sel = item_q.gyro_x;
      AX_ROLL:  gyro_sel = item_q.gyro_y;
      AX_YAW:   gyro_sel = item_q.gyro_z;
      default:  gyro_sel = '0;
    endcase
  end

  assign g250   = ((FieldW+9)'(gyro_sel) <<< 8) - ((FieldW+9)'(gyro_sel) <<< 2)
                - ((FieldW+9)'(gyro_sel) <<< 1);
  assign rate_a = MulAW'(g250) <<< range_q;
  assign step_b = $signed({{(MulBW-StepW){1'b0}}, time_step_q});

  imu_caf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign cordic_y = (axis_q == AX_PITCH) ? item_q.accel_y : item_q.accel_x;

  imu_caf_cordic #(
    .Steps (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .y_i     (cordic_y),
    .x_i     (item_q.accel_z),
    .done_o  (cordic_done),
    .z_o     (cordic_z)
  );

  // integration and blend arithmetic on the registered product
  assign int_round   = mul_p + MulPW'(RoundInt);
  assign int_inc     = int_round >>> IntShift;
  assign int_sum     = (AngW+2)'(angle_q[axis_q]) + $signed(int_inc[AngW+1:0]);
  assign int_angle   = sat_ang(AccW'(int_sum));
  assign blend_sum   = acc_q + AccW'(mul_p);
  assign blend_shift = blend_sum >>> BlendShift;
  assign blend_angle = sat_ang(blend_shift);

  always_comb begin
    state_d      = state_q;
    axis_d       = axis_q;
    angle_d      = angle_q;
    tilt_d       = tilt_q;
    acc_d        = acc_q;
    out_data_d   = out_data_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    cordic_start = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          axis_d  = AX_PITCH;
          state_d = ST_INT_MUL;
        end
      end
      ST_INT_MUL: begin
        mul_a   = rate_a;
        mul_b   = step_b;
        state_d = ST_INT_ADD;
      end
      ST_INT_ADD: begin
        angle_d[axis_q] = int_angle;
        case (axis_q)
          AX_PITCH: begin
            axis_d  = AX_ROLL;
            state_d = ST_INT_MUL;
          end
          AX_ROLL: begin
            axis_d  = AX_YAW;
            state_d = ST_INT_MUL;
          end
          default: begin
            axis_d  = AX_PITCH;
            state_d = blend_q ? ST_ATAN_START : ST_DONE;
          end
        endcase
      end
      ST_ATAN_START: begin
        cordic_start = 1'b1;
        state_d      = ST_ATAN_WAIT;
      end
      ST_ATAN_WAIT: begin
        if (cordic_done) begin
          tilt_d  = cordic_z;
          state_d = ST_BLEND_ANG;
        end
      end
      ST_BLEND_ANG: begin
        mul_a   = MulAW'(angle_q[axis_q]);
        mul_b   = MulBW'(BlendKeep);
        state_d = ST_BLEND_TILT;
      end
      ST_BLEND_TILT: begin
        mul_a   = MulAW'(tilt_q);
        mul_b   = MulBW'(BlendGain);
        acc_d   = AccW'(mul_p) + AccW'(BlendHalf);
        state_d = ST_BLEND_ADD;
      end
      ST_BLEND_ADD: begin
        angle_d[axis_q] = blend_angle;
        if (axis_q == AX_PITCH) begin
          axis_d  = AX_ROLL;
          state_d = ST_ATAN_START;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d              = 1'b1;
          out_data_d.pitch_deg     = angle_q[AX_PITCH];
          out_data_d.roll_deg      = angle_q[AX_ROLL];
          out_data_d.yaw_deg       = angle_q[AX_YAW];
          out_data_d.accel_blended = blend_q;
          state_d                  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= AX_PITCH;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumAxes; i++) begin
        angle_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
      angle_q     <= angle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tilt_q     <= tilt_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
    if (in_i.valid && in_i.ready) begin
      item_q  <= in_i.data;
      blend_q <= mag_ok;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q     <= RangeW'(RangeReset);
      time_step_q <= StepW'(StepReset);
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.data.index)
        REG_GYRO_RANGE: range_q     <= cfg_i.data.value[RangeW-1:0];
        REG_TIME_STEP:  time_step_q <= cfg_i.data.value[StepW-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

`ifndef NO_ASSERTIONS
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result raised outside the done state");

  a_cordic_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_done |-> state_q == ST_ATAN_WAIT)
    else $error("cordic finished while not awaited");

  a_atan_needs_blend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ATAN_START |-> blend_q)
    else $error("tilt correction started without a magnitude in band");

  a_done_hands_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && (!out_valid_q || out_o.ready) |=>
      out_valid_q && (state_q == ST_IDLE))
    else $error("finished transaction not loaded into the output register");
`endif

endmodule
